[rtl/rht_pkg.sv]
// Package: shared types and constants of the refcounted host table
`timescale 1ns / 1ps
package rht_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = 5;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_CPUSH  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSED  = 2'd2,
    ST_SKIPPED = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic        data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] count;
    logic        gvalid;
    logic [31:0] gid;
    logic [CntW-1:0] active;
  } rsp_t;
endpackage

[rtl/rht_front.sv]
// Front end: accept items, normalize the address and queue them
`timescale 1ns / 1ps
module rht_front import rht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic        is_ipv6_i,
  input  logic [63:0] host_addr_high_i,
  input  logic [63:0] host_addr_low_i,
  input  logic [15:0] host_port_i,
  input  logic        is_data_report_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output req_t        q_req_o
);
  req_t req_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;
  req_t       in_req;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = req_q[rd_q];

  always_comb begin
    in_req.op   = operation_i;
    in_req.v6   = is_ipv6_i;
    in_req.hi   = is_ipv6_i ? host_addr_high_i : 64'd0;
    in_req.lo   = is_ipv6_i ? host_addr_low_i : {32'd0, host_addr_low_i[31:0]};
    in_req.port = host_port_i;
    in_req.data = is_data_report_i;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) req_q[wr_q] <= in_req;
  end
endmodule

[rtl/rht_back.sv]
// Back end: look up the table, update the entry and register the result
`timescale 1ns / 1ps
module rht_back import rht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  req_t        q_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        rsp_o
);
  localparam logic S_LOOK = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic            state_q;
  logic [Entries-1:0] valid_q;
  logic [Entries-1:0] v6_q;
  logic [63:0]     hi_q   [Entries];
  logic [63:0]     lo_q   [Entries];
  logic [15:0]     port_q [Entries];
  logic [15:0]     ref_q  [Entries];
  logic [Entries-1:0] hg_q;
  logic [31:0]     grp_q  [Entries];
  logic [CntW-1:0] occ_q;
  logic [31:0]     total_q;

  logic [Entries-1:0] hit_q;
  logic [IdxW-1:0] hidx, fidx;
  logic            hhit, fhit;
  logic [Entries-1:0] match;
  logic            ovalid_q;
  logic            skip;
  rsp_t            rsp_q, rsp_d;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (v6_q[i] == q_req_i.v6) &&
                 (hi_q[i] == q_req_i.hi) && (lo_q[i] == q_req_i.lo);
    end
  end

  always_comb begin
    hidx = '0; hhit = 1'b0; fidx = '0; fhit = 1'b0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (hit_q[i]) begin hidx = IdxW'(i); hhit = 1'b1; end
      if (!valid_q[i]) begin fidx = IdxW'(i); fhit = 1'b1; end
    end
  end

  assign skip = hhit && (q_req_i.op == OP_CPUSH) && (port_q[hidx] == q_req_i.port);

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = ST_DONE;
    rsp_d.active = occ_q;
    case (q_req_i.op)
      OP_REMOVE: begin
        if (!hhit) rsp_d.status = ST_MISSED;
        else begin
          rsp_d.found = 1'b1;
          rsp_d.gid   = hg_q[hidx] ? grp_q[hidx] : 32'd0;
          rsp_d.count = (ref_q[hidx] != 16'd0) ? ref_q[hidx] - 16'd1 : 16'd0;
          if (ref_q[hidx] <= 16'd1 && occ_q != '0) rsp_d.active = occ_q - 1'b1;
        end
      end
      OP_PUSH, OP_CPUSH: begin
        if (skip) begin
          rsp_d.status = ST_SKIPPED;
          rsp_d.found  = 1'b1;
          rsp_d.count  = ref_q[hidx];
          rsp_d.gid    = hg_q[hidx] ? grp_q[hidx] : 32'd0;
        end else if (hhit) begin
          rsp_d.found  = 1'b1;
          rsp_d.count  = (ref_q[hidx] != 16'hFFFF) ? ref_q[hidx] + 16'd1 : ref_q[hidx];
          rsp_d.gid    = hg_q[hidx] ? grp_q[hidx] : 32'd0;
          rsp_d.gvalid = q_req_i.data && hg_q[hidx];
        end else if (!fhit) begin
          rsp_d.status = ST_FULL;
        end else begin
          rsp_d.count  = 16'd1;
          rsp_d.gvalid = q_req_i.data;
          rsp_d.gid    = q_req_i.data ? total_q + 32'd1 : 32'd0;
          rsp_d.active = occ_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign q_pop_o = (state_q == S_EXEC) && (!ovalid_q || !out_stall_i);
  assign out_valid_o = ovalid_q;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOOK;
      valid_q  <= '0;
      occ_q    <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (q_pop_o) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_LOOK: if (q_valid_i) state_q <= S_EXEC;
        S_EXEC: if (q_pop_o) begin
          state_q <= S_LOOK;
          case (q_req_i.op)
            OP_REMOVE: if (hhit && ref_q[hidx] <= 16'd1) begin
              valid_q[hidx] <= 1'b0;
              if (occ_q != '0) occ_q <= occ_q - 1'b1;
            end
            OP_PUSH, OP_CPUSH: if (!hhit && fhit) begin
              valid_q[fidx] <= 1'b1;
              occ_q   <= occ_q + 1'b1;
              total_q <= total_q + 32'd1;
            end
            default: ;
          endcase
        end
        default: state_q <= S_LOOK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) hit_q <= match;
    if (q_pop_o) begin
      rsp_q <= rsp_d;
      case (q_req_i.op)
        OP_REMOVE: if (hhit) ref_q[hidx] <= rsp_d.count;
        OP_PUSH, OP_CPUSH: begin
          if (hhit && !skip) ref_q[hidx] <= rsp_d.count;
          else if (!hhit && fhit) begin
            v6_q[fidx]   <= q_req_i.v6;
            hi_q[fidx]   <= q_req_i.hi;
            lo_q[fidx]   <= q_req_i.lo;
            port_q[fidx] <= q_req_i.port;
            ref_q[fidx]  <= 16'd1;
            hg_q[fidx]   <= q_req_i.data;
            grp_q[fidx]  <= total_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/refcounted_host_table.sv]
// Top level of the refcounted host table
// Each item passes through two back-end states: one compares the host against
// all sixteen entries, the next updates the matching or lowest free entry and
// registers the result. A two-entry queue in front accepts items while the
// back end works or its result waits. No clearing pass follows reset.
`timescale 1ns / 1ps
module refcounted_host_table import rht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic        is_ipv6_i,
  input  logic [63:0] host_addr_high_i,
  input  logic [63:0] host_addr_low_i,
  input  logic [15:0] host_port_i,
  input  logic        is_data_report_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        found_existing_o,
  output logic [15:0] thread_count_o,
  output logic        group_valid_o,
  output logic [31:0] group_id_o,
  output logic [4:0]  active_hosts_o
);
  logic q_valid, q_pop;
  req_t q_req;
  rsp_t rsp;

  rht_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .is_ipv6_i,
    .host_addr_high_i, .host_addr_low_i, .host_port_i, .is_data_report_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  rht_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .out_valid_o, .out_stall_i, .rsp_o(rsp)
  );

  assign status_o         = rsp.status;
  assign found_existing_o = rsp.found;
  assign thread_count_o   = rsp.count;
  assign group_valid_o    = rsp.gvalid;
  assign group_id_o       = rsp.gid;
  assign active_hosts_o   = rsp.active;
endmodule

[rtl/rht_checker.sv]
// Checker: port-level properties of the refcounted host table
`timescale 1ns / 1ps
module rht_checker import rht_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic        found_existing_o,
  input logic [15:0] thread_count_o,
  input logic        group_valid_o,
  input logic [4:0]  active_hosts_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(thread_count_o))
    else $error("stalled result changed");
  a_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> active_hosts_o <= 5'd16)
    else $error("active hosts out of range");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_MISSED) |->
    !found_existing_o && thread_count_o == 16'd0 && !group_valid_o)
    else $error("miss result carries data");
  a_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SKIPPED |-> found_existing_o && !group_valid_o)
    else $error("skip result malformed");
endmodule

bind refcounted_host_table rht_checker u_rht_checker (.*);

[dv/refcounted_host_table_tb.sv]
// Testbench: refcounted host table checked against a behavioral table model
`timescale 1ns / 1ps
module refcounted_host_table_tb;
  import rht_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] count;
    logic        gvalid;
    logic [31:0] gid;
    logic [4:0]  active;
  } host_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_PUSH;
  logic        is_ipv6_i = 1'b0;
  logic [63:0] host_addr_high_i = '0;
  logic [63:0] host_addr_low_i = '0;
  logic [15:0] host_port_i = '0;
  logic        is_data_report_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        found_existing_o;
  logic [15:0] thread_count_o;
  logic        group_valid_o;
  logic [31:0] group_id_o;
  logic [4:0]  active_hosts_o;

  refcounted_host_table DUT (.*);

  always #5 clk_i = ~clk_i;

  // host table mirror
  logic        tbl_used [Entries];
  logic        tbl_v6 [Entries];
  logic [63:0] tbl_hi [Entries];
  logic [63:0] tbl_lo [Entries];
  logic [15:0] tbl_port [Entries];
  logic [15:0] tbl_refs [Entries];
  logic        tbl_grp [Entries];
  logic [31:0] tbl_gid [Entries];
  int unsigned hosts_in_use;
  logic [31:0] creations;

  host_rsp_t   expected_rsps [$];
  int          mismatches = 0;
  int          sent = 0;
  int          rsps_seen = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  longint      cycles = 0;

  // pool of hosts so that pushes and removes hit each other
  logic        pool_v6 [24];
  logic [63:0] pool_hi [24];
  logic [63:0] pool_lo [24];

  function automatic host_rsp_t predict_table(logic [1:0] op, logic v6, logic [63:0] hi_in,
                                              logic [63:0] lo_in, logic [15:0] port,
                                              logic data);
    host_rsp_t r;
    int idx;
    int fr;
    logic [63:0] hi;
    logic [63:0] lo;
    r = '0;
    idx = -1;
    fr = -1;
    hi = v6 ? hi_in : 64'd0;
    lo = v6 ? lo_in : {32'd0, lo_in[31:0]};
    for (int i = 0; i < Entries; i++) begin
      if (idx < 0 && tbl_used[i] && tbl_v6[i] == v6 && tbl_hi[i] == hi && tbl_lo[i] == lo)
        idx = i;
      if (fr < 0 && !tbl_used[i]) fr = i;
    end
    if (op == OP_REMOVE) begin
      if (idx < 0) r.status = ST_MISSED;
      else begin
        r.found = 1'b1;
        r.gid = tbl_grp[idx] ? tbl_gid[idx] : 32'd0;
        if (tbl_refs[idx] > 0) tbl_refs[idx]--;
        r.count = tbl_refs[idx];
        if (tbl_refs[idx] == 0) begin
          tbl_used[idx] = 1'b0;
          if (hosts_in_use > 0) hosts_in_use--;
        end
      end
    end else if (op == OP_PUSH || op == OP_CPUSH) begin
      if (op == OP_CPUSH && idx >= 0 && tbl_port[idx] == port) begin
        r.status = ST_SKIPPED;
        r.found = 1'b1;
        r.count = tbl_refs[idx];
        r.gid = tbl_grp[idx] ? tbl_gid[idx] : 32'd0;
      end else if (idx >= 0) begin
        r.found = 1'b1;
        if (tbl_refs[idx] != 16'hFFFF) tbl_refs[idx]++;
        r.count = tbl_refs[idx];
        r.gid = tbl_grp[idx] ? tbl_gid[idx] : 32'd0;
        r.gvalid = data & tbl_grp[idx];
      end else if (fr < 0) begin
        r.status = ST_FULL;
      end else begin
        creations++;
        tbl_used[fr] = 1'b1;
        tbl_v6[fr] = v6;
        tbl_hi[fr] = hi;
        tbl_lo[fr] = lo;
        tbl_port[fr] = port;
        tbl_refs[fr] = 16'd1;
        tbl_grp[fr] = data;
        tbl_gid[fr] = creations;
        hosts_in_use++;
        r.count = 16'd1;
        r.gvalid = data;
        r.gid = data ? creations : 32'd0;
      end
    end
    r.active = hosts_in_use[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch on %s: got %0h expected %0h (response %0d)", what, got, want,
             rsps_seen);
  endtask

  task automatic send_host(logic [1:0] op, logic v6, logic [63:0] hi, logic [63:0] lo,
                           logic [15:0] port, logic data);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    expected_rsps.push_back(predict_table(op, v6, hi, lo, port, data));
    in_valid_i <= 1'b1;
    operation_i <= op;
    is_ipv6_i <= v6;
    host_addr_high_i <= hi;
    host_addr_low_i <= lo;
    host_port_i <= port;
    is_data_report_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    host_rsp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsps_seen++;
      if (expected_rsps.size() == 0) report_mismatch("unexpected transfer", 1, 0);
      else begin
        w = expected_rsps.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (found_existing_o !== w.found) report_mismatch("found", found_existing_o, w.found);
        if (thread_count_o !== w.count) report_mismatch("count", thread_count_o, w.count);
        if (group_valid_o !== w.gvalid) report_mismatch("gvalid", group_valid_o, w.gvalid);
        if (group_id_o !== w.gid) report_mismatch("group_id", group_id_o, w.gid);
        if (active_hosts_o !== w.active) report_mismatch("active", active_hosts_o, w.active);
      end
    end
  end

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pool(logic [1:0] op, int p, logic [15:0] port, logic data);
    send_host(op, pool_v6[p], pool_hi[p], pool_lo[p], port, data);
  endtask

  task automatic test_directed;
    // fill the table, overflow it, then remove some of its hosts again
    for (int i = 0; i < 16; i++)
      send_pool(OP_PUSH, i, 16'(i * 4099), i[0]);
    send_pool(OP_PUSH, 16, 16'hFFFF, 1'b1);
    send_pool(OP_CPUSH, 3, 16'(3 * 4099), 1'b1);
    send_pool(OP_CPUSH, 4, 16'h0000, 1'b1);
    send_pool(OP_REMOVE, 17, 16'h0, 1'b0);
    send_host(OP_NONE, 1'b1, '1, '1, '1, 1'b1);
    // IPv4 ignores the upper address bits
    send_host(OP_PUSH, 1'b0, '1, {32'hFFFF_FFFF, pool_lo[5][31:0]}, 16'h1, 1'b1);
    for (int i = 0; i < 3; i++) send_pool(OP_REMOVE, 1, 16'h0, 1'b0);
    send_pool(OP_REMOVE, 0, 16'h0, 1'b0);
    drain();
  endtask

  task automatic test_repeat;
    // stack many references on one host, then drop one
    send_pool(OP_PUSH, 20, 16'h55AA, 1'b1);
    for (int i = 0; i < 100; i++) send_pool(OP_PUSH, 20, 16'h0, 1'b0);
    send_pool(OP_REMOVE, 20, 16'h0, 1'b0);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    int p;
    int k;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      p = $urandom_range(23);
      if (k < 4)
        send_host(2'($urandom_range(3)), 1'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, 16'($urandom), 1'($urandom));
      else if (k < 45)
        send_pool(OP_PUSH, p, 16'($urandom_range(3)), 1'($urandom));
      else if (k < 60)
        send_pool(OP_CPUSH, p, 16'($urandom_range(3)), 1'($urandom));
      else
        send_pool(OP_REMOVE, p, 16'($urandom), 1'($urandom));
    end
    drain();
    send_idle = 0;
    recv_stall = 0;
  endtask

  initial begin
    for (int i = 0; i < Entries; i++) tbl_used[i] = 1'b0;
    hosts_in_use = 0;
    creations = '0;
    for (int i = 0; i < 24; i++) begin
      pool_v6[i] = i[0];
      pool_hi[i] = i[0] ? {$urandom, $urandom} : 64'd0;
      pool_lo[i] = i[0] ? {$urandom, $urandom} : {32'd0, $urandom};
    end
    pool_hi[1] = '1;
    pool_lo[1] = '1;
    pool_lo[2] = {32'd0, 32'hFFFF_FFFF};
    pool_hi[3] = '0;
    pool_lo[3] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(320, 0, 0);
    test_random(320, 80, 0);
    test_random(320, 0, 80);
    test_random(320, 34, 34);
    test_repeat();
    $display("covered %0d transfers: table fill and overflow, conditional skips, misses,", sent);
    $display("repeated pushes on one host, and random host traffic under idle and stall phases");
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
